/* rtl/sae_pkg.sv */
// Shared types, codes and the microcode program of the set algebra engine.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package sae_pkg;

    // Default capacity of each set.
    localparam int SAE_DEPTH = 16;
    localparam int DATA_W    = 32;

    // Command opcodes.
    localparam logic [2:0] OPC_CLEAR     = 3'd0;
    localparam logic [2:0] OPC_ADD_A     = 3'd1;
    localparam logic [2:0] OPC_ADD_B     = 3'd2;
    localparam logic [2:0] OPC_UNION     = 3'd3;
    localparam logic [2:0] OPC_INTER     = 3'd4;
    localparam logic [2:0] OPC_A_MINUS_B = 3'd5;
    localparam logic [2:0] OPC_B_MINUS_A = 3'd6;
    localparam logic [2:0] OPC_UNUSED    = 3'd7;

    // Result status codes.
    localparam logic [2:0] ST_ELEM    = 3'd0;
    localparam logic [2:0] ST_ADDED   = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    // Micro-operations.
    localparam logic [2:0] UOP_NOP   = 3'd0;
    localparam logic [2:0] UOP_CLEAR = 3'd1;
    localparam logic [2:0] UOP_ADD   = 3'd2;
    localparam logic [2:0] UOP_WALK  = 3'd3;
    localparam logic [2:0] UOP_FLUSH = 3'd4;

    // Membership filters applied during a walk.
    localparam logic [1:0] FILT_ALL = 2'd0;
    localparam logic [1:0] FILT_IN  = 2'd1;
    localparam logic [1:0] FILT_OUT = 2'd2;

    // Microcode addresses.
    localparam logic [3:0] UA_CLEAR   = 4'd0;
    localparam logic [3:0] UA_ADD_A   = 4'd1;
    localparam logic [3:0] UA_ADD_B   = 4'd2;
    localparam logic [3:0] UA_UNION_A = 4'd3;
    localparam logic [3:0] UA_UNION_B = 4'd4;
    localparam logic [3:0] UA_INTER   = 4'd5;
    localparam logic [3:0] UA_AMB     = 4'd6;
    localparam logic [3:0] UA_BMA     = 4'd7;
    localparam logic [3:0] UA_NOP     = 4'd8;
    localparam logic [3:0] UA_FLUSH   = 4'd9;

    // One control word of the program.
    typedef struct packed {
        logic [2:0] uop;
        logic       sel_b;
        logic [1:0] filt;
        logic       fin;
        logic [3:0] nxt;
    } sae_uword_t;

    // Control from the sequencer to the datapath for the current step.
    typedef struct packed {
        logic       clear;
        logic       add_a;
        logic       add_b;
        logic       walk;
        logic       walk_b;
        logic [1:0] filt;
        logic       flush;
    } sae_ctl_t;

    // Program ROM.
    function automatic sae_uword_t sae_rom(input logic [3:0] addr);
        sae_uword_t w;
        unique case (addr)
            UA_CLEAR:   w = '{uop: UOP_CLEAR, sel_b: 1'b0, filt: FILT_ALL, fin: 1'b1,
                              nxt: UA_NOP};
            UA_ADD_A:   w = '{uop: UOP_ADD,   sel_b: 1'b0, filt: FILT_ALL, fin: 1'b1,
                              nxt: UA_NOP};
            UA_ADD_B:   w = '{uop: UOP_ADD,   sel_b: 1'b1, filt: FILT_ALL, fin: 1'b1,
                              nxt: UA_NOP};
            UA_UNION_A: w = '{uop: UOP_WALK,  sel_b: 1'b0, filt: FILT_ALL, fin: 1'b0,
                              nxt: UA_UNION_B};
            UA_UNION_B: w = '{uop: UOP_WALK,  sel_b: 1'b1, filt: FILT_OUT, fin: 1'b0,
                              nxt: UA_FLUSH};
            UA_INTER:   w = '{uop: UOP_WALK,  sel_b: 1'b0, filt: FILT_IN,  fin: 1'b0,
                              nxt: UA_FLUSH};
            UA_AMB:     w = '{uop: UOP_WALK,  sel_b: 1'b0, filt: FILT_OUT, fin: 1'b0,
                              nxt: UA_FLUSH};
            UA_BMA:     w = '{uop: UOP_WALK,  sel_b: 1'b1, filt: FILT_OUT, fin: 1'b0,
                              nxt: UA_FLUSH};
            UA_FLUSH:   w = '{uop: UOP_FLUSH, sel_b: 1'b0, filt: FILT_ALL, fin: 1'b1,
                              nxt: UA_NOP};
            default:    w = '{uop: UOP_NOP,   sel_b: 1'b0, filt: FILT_ALL, fin: 1'b1,
                              nxt: UA_NOP};
        endcase
        return w;
    endfunction

    // Entry point of the program for each opcode.
    function automatic logic [3:0] sae_dispatch(input logic [2:0] opc);
        logic [3:0] a;
        unique case (opc)
            OPC_CLEAR:     a = UA_CLEAR;
            OPC_ADD_A:     a = UA_ADD_A;
            OPC_ADD_B:     a = UA_ADD_B;
            OPC_UNION:     a = UA_UNION_A;
            OPC_INTER:     a = UA_INTER;
            OPC_A_MINUS_B: a = UA_AMB;
            OPC_B_MINUS_A: a = UA_BMA;
            OPC_UNUSED:    a = UA_NOP;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* rtl/sae_set_store.sv */
// Storage for one set: entries in insertion order, a fill count,
// a parallel membership compare and one indexed read port. Uses sae_pkg.
`default_nettype none

module sae_set_store
    import sae_pkg::*;
#(
    parameter int DEPTH = SAE_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     clr,
    input  wire logic                     add_en,
    input  wire logic signed [DATA_W-1:0] probe_val,
    output logic                          probe_hit,
    output logic                          full,
    input  wire logic [IDX_W-1:0]         rd_idx,
    output logic signed [DATA_W-1:0]      rd_val,
    output logic [CNT_W-1:0]              count
);

    logic signed [DATA_W-1:0] items_reg [DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     wr_en;

    // Membership compare against every filled entry.
    always_comb
    begin
        probe_hit = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if ((CNT_W'(i) < count_reg) && (items_reg[i] == probe_val))
            begin
                probe_hit = 1'b1;
            end
        end
    end

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign wr_en  = add_en && !probe_hit && !full;
    assign rd_val = items_reg[rd_idx];
    assign count  = count_reg;

    // Fill count: clear empties the set, an accepted add appends.
    always_comb
    begin
        count_next = count_reg;
        if (clr)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entry storage, written at the fill position.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            items_reg[count_reg[IDX_W-1:0]] <= probe_val;
        end
    end

endmodule

`default_nettype wire

/* rtl/sae_sequencer.sv */
// Microcode sequencer: program counter, walk index and busy flag.
// Steps through the program ROM in sae_pkg and issues one control word per cycle.
`default_nettype none

module sae_sequencer
    import sae_pkg::*;
#(
    parameter int DEPTH = SAE_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [2:0]       opcode,
    input  wire logic [CNT_W-1:0] cnt_a,
    input  wire logic [CNT_W-1:0] cnt_b,
    output logic                  busy,
    output sae_ctl_t              ctl,
    output logic [IDX_W-1:0]      idx
);

    logic             busy_reg;
    logic             busy_next;
    logic [3:0]       upc_reg;
    logic [3:0]       upc_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    sae_uword_t       uw;
    logic [CNT_W-1:0] src_cnt;
    logic             walk_end;

    assign uw       = sae_rom(upc_reg);
    assign src_cnt  = uw.sel_b ? cnt_b : cnt_a;
    assign walk_end = (idx_reg == src_cnt);

    // Next program counter, walk index and busy flag.
    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        idx_next  = idx_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                upc_next  = sae_dispatch(opcode);
                idx_next  = '0;
            end
        end
        else if (uw.uop == UOP_WALK)
        begin
            if (walk_end)
            begin
                idx_next = '0;
                upc_next = uw.nxt;
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
        else if (uw.fin)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            upc_next = uw.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= UA_NOP;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
            idx_reg  <= idx_next;
        end
    end

    // Decode the control word into datapath strobes.
    always_comb
    begin
        ctl.clear  = busy_reg && (uw.uop == UOP_CLEAR);
        ctl.add_a  = busy_reg && (uw.uop == UOP_ADD) && !uw.sel_b;
        ctl.add_b  = busy_reg && (uw.uop == UOP_ADD) && uw.sel_b;
        ctl.walk   = busy_reg && (uw.uop == UOP_WALK) && !walk_end;
        ctl.walk_b = uw.sel_b;
        ctl.filt   = uw.filt;
        ctl.flush  = busy_reg && (uw.uop == UOP_FLUSH);
    end

    assign busy = busy_reg;
    assign idx  = idx_reg[IDX_W-1:0];

endmodule

`default_nettype wire

/* rtl/set_algebra_engine.sv */
// Timing: add, clear and the unused opcode end at their entry step; an add result is checked
// in the add step and registered onto the ports, and the next item can be taken at its end.
// An operation walks its source set (both sets for union), one stored element per cycle,
// then runs a flush step; busy stays high throughout and the next item follows once it drops.
// A kept element waits until the next one is found or the flush step, then leaves in the next
// cycle; the receiver cannot stall. Reset (rst_n, async, active low) empties both sets.
`default_nettype none

module set_algebra_engine
    import sae_pkg::*;
#(
    parameter int DEPTH = SAE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               opcode,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          result_valid,
    output logic [2:0]                    status,
    output logic signed [DATA_W-1:0]      value_res,
    output logic                          last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    sae_ctl_t                 ctl;
    logic [IDX_W-1:0]         idx;
    logic [CNT_W-1:0]         cnt_a;
    logic [CNT_W-1:0]         cnt_b;
    logic                     hit_a;
    logic                     hit_b;
    logic                     full_a;
    logic                     full_b;
    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;
    logic signed [DATA_W-1:0] probe_a;
    logic signed [DATA_W-1:0] probe_b;
    logic                     accept;

    logic signed [DATA_W-1:0] value_reg;
    logic                     pend_vld_reg;
    logic                     pend_vld_next;
    logic signed [DATA_W-1:0] pend_val_reg;
    logic signed [DATA_W-1:0] pend_val_next;
    logic [CNT_W-1:0]         keep_cnt_reg;
    logic [CNT_W-1:0]         keep_cnt_next;
    logic                     out_vld_reg;
    logic                     out_vld_next;
    logic [2:0]               out_st_reg;
    logic [2:0]               out_st_next;
    logic signed [DATA_W-1:0] out_val_reg;
    logic signed [DATA_W-1:0] out_val_next;
    logic                     out_last_reg;
    logic                     out_last_next;

    logic signed [DATA_W-1:0] elem;
    logic                     other_hit;
    logic                     keep;
    logic                     add_hit;
    logic                     add_full;

    assign accept = start && !busy;

    sae_sequencer #(
        .DEPTH(DEPTH),
        .CNT_W(CNT_W),
        .IDX_W(IDX_W)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .opcode(opcode),
        .cnt_a (cnt_a),
        .cnt_b (cnt_b),
        .busy  (busy),
        .ctl   (ctl),
        .idx   (idx)
    );

    // Each set is probed with the offered value on its own add, else with the
    // element the other set is walking.
    assign probe_a = ctl.add_a ? value_reg : rd_b;
    assign probe_b = ctl.add_b ? value_reg : rd_a;

    sae_set_store #(
        .DEPTH(DEPTH),
        .CNT_W(CNT_W),
        .IDX_W(IDX_W)
    ) u_set_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (ctl.clear),
        .add_en   (ctl.add_a),
        .probe_val(probe_a),
        .probe_hit(hit_a),
        .full     (full_a),
        .rd_idx   (idx),
        .rd_val   (rd_a),
        .count    (cnt_a)
    );

    sae_set_store #(
        .DEPTH(DEPTH),
        .CNT_W(CNT_W),
        .IDX_W(IDX_W)
    ) u_set_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (ctl.clear),
        .add_en   (ctl.add_b),
        .probe_val(probe_b),
        .probe_hit(hit_b),
        .full     (full_b),
        .rd_idx   (idx),
        .rd_val   (rd_b),
        .count    (cnt_b)
    );

    // Walk filter: keep the element when its membership matches and room remains.
    assign elem      = ctl.walk_b ? rd_b : rd_a;
    assign other_hit = ctl.walk_b ? hit_a : hit_b;
    assign keep      = ctl.walk && (keep_cnt_reg < CNT_W'(DEPTH))
                       && ((ctl.filt == FILT_ALL)
                           || ((ctl.filt == FILT_IN) && other_hit)
                           || ((ctl.filt == FILT_OUT) && !other_hit));
    assign add_hit   = ctl.add_a ? hit_a : hit_b;
    assign add_full  = ctl.add_a ? full_a : full_b;

    // Result path: one kept element waits so that the final item can carry last.
    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_val_next = pend_val_reg;
        keep_cnt_next = keep_cnt_reg;
        out_vld_next  = 1'b0;
        out_st_next   = out_st_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        if (accept)
        begin
            pend_vld_next = 1'b0;
            keep_cnt_next = '0;
        end
        else if (ctl.add_a || ctl.add_b)
        begin
            out_vld_next  = 1'b1;
            out_val_next  = value_reg;
            out_last_next = 1'b1;
            if (add_hit)
            begin
                out_st_next = ST_PRESENT;
            end
            else if (add_full)
            begin
                out_st_next = ST_FULL;
            end
            else
            begin
                out_st_next = ST_ADDED;
            end
        end
        else if (keep)
        begin
            if (pend_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_st_next   = ST_ELEM;
                out_val_next  = pend_val_reg;
                out_last_next = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_val_next = elem;
            keep_cnt_next = keep_cnt_reg + CNT_W'(1);
        end
        else if (ctl.flush)
        begin
            out_vld_next  = 1'b1;
            out_last_next = 1'b1;
            pend_vld_next = 1'b0;
            if (pend_vld_reg)
            begin
                out_st_next  = ST_ELEM;
                out_val_next = pend_val_reg;
            end
            else
            begin
                out_st_next  = ST_EMPTY;
                out_val_next = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            keep_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            keep_cnt_reg <= keep_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
        end
        pend_val_reg <= pend_val_next;
        out_st_reg   <= out_st_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    assign result_valid = out_vld_reg;
    assign status       = out_st_reg;
    assign value_res    = out_val_reg;
    assign last         = out_last_reg;

    // A waiting element has always been counted against the cap.
    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (keep_cnt_reg != '0))
        else $error("waiting element without a kept count");

    // Add and empty results are single items and must end the response.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_ADDED || status == ST_PRESENT
                          || status == ST_FULL || status == ST_EMPTY)) |-> last)
        else $error("single-item result without last");

    // Set fill counts never pass the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a <= CNT_W'(DEPTH)) && (cnt_b <= CNT_W'(DEPTH)))
        else $error("set count beyond capacity");

    // The kept count never passes the capacity.
    a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        keep_cnt_reg <= CNT_W'(DEPTH))
        else $error("result count beyond capacity");

    // An accepted item always occupies the engine in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not start the sequencer");

endmodule

`default_nettype wire

/* tb/set_algebra_engine_test.sv */
// Self-checking testbench for the set algebra engine: directed and random item streams,
// with every result checked against a behavioral predictor of the two sets.
// Depends on rtl/sae_pkg.sv and rtl/set_algebra_engine.sv.
`default_nettype none

module set_algebra_engine_test;
    import sae_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = SAE_DEPTH;
    localparam int SET_A = 0;
    localparam int SET_B = 1;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef logic signed [DATA_W-1:0] elem_t;

    typedef struct {
        logic [2:0] status;
        elem_t      elem;
        logic       last;
    } set_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] opcode = OPC_CLEAR;
    elem_t      value = '0;
    logic       busy;
    logic       result_valid;
    logic [2:0] status;
    elem_t      value_res;
    logic       last;

    // Predicted contents of both sets and results still to come out of the block.
    elem_t       set_elems [2][DEPTH];
    int          set_count [2];
    elem_t       walk_out [$];
    set_result_t predicted_results [$];
    int          error_count = 0;
    bit          no_gaps = 1'b0;

    set_algebra_engine #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .value(value),
        .result_valid(result_valid),
        .status(status),
        .value_res(value_res),
        .last(last)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard limit on the run time in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit set_holds(input int which, input elem_t v);
        for (int i = 0; i < set_count[which]; i++)
        begin
            if (set_elems[which][i] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Walk one set in order; keep filtered elements not yet kept, up to DEPTH of them.
    task automatic walk_set(input int src, input int other, input logic [1:0] filt);
        elem_t v;
        bit    keep;
        bit    dup;
        for (int i = 0; i < set_count[src]; i++)
        begin
            v = set_elems[src][i];
            keep = (filt == FILT_ALL) ||
                   (filt == FILT_IN && set_holds(other, v)) ||
                   (filt == FILT_OUT && !set_holds(other, v));
            dup = 1'b0;
            foreach (walk_out[j])
            begin
                if (walk_out[j] == v)
                    dup = 1'b1;
            end
            if (keep && !dup && walk_out.size() < DEPTH)
                walk_out.push_back(v);
        end
    endtask

    // Update the predicted sets for one accepted item and queue the results it causes.
    task automatic apply_set_command(input logic [2:0] op, input elem_t v);
        int          which;
        set_result_t r;
        walk_out.delete();
        case (op)
            OPC_CLEAR:
            begin
                set_count[SET_A] = 0;
                set_count[SET_B] = 0;
            end
            OPC_ADD_A, OPC_ADD_B:
            begin
                which = (op == OPC_ADD_B) ? SET_B : SET_A;
                // Membership is tested before capacity.
                if (set_holds(which, v))
                    r.status = ST_PRESENT;
                else if (set_count[which] >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    set_elems[which][set_count[which]] = v;
                    set_count[which]++;
                    r.status = ST_ADDED;
                end
                r.elem = v;
                r.last = 1'b1;
                predicted_results.push_back(r);
            end
            OPC_UNION:
            begin
                walk_set(SET_A, SET_B, FILT_ALL);
                walk_set(SET_B, SET_A, FILT_ALL);
            end
            OPC_INTER:     walk_set(SET_A, SET_B, FILT_IN);
            OPC_A_MINUS_B: walk_set(SET_A, SET_B, FILT_OUT);
            OPC_B_MINUS_A: walk_set(SET_B, SET_A, FILT_OUT);
            default:       ;
        endcase

        // Set operations stream their result, or a single empty marker.
        if (op == OPC_UNION || op == OPC_INTER || op == OPC_A_MINUS_B ||
            op == OPC_B_MINUS_A)
        begin
            if (walk_out.size() == 0)
            begin
                r.status = ST_EMPTY;
                r.elem = '0;
                r.last = 1'b1;
                predicted_results.push_back(r);
            end
            foreach (walk_out[i])
            begin
                r.status = ST_ELEM;
                r.elem = walk_out[i];
                r.last = (i == walk_out.size() - 1);
                predicted_results.push_back(r);
            end
        end
    endtask

    // Present one item, wait until it is taken and busy drops, then idle for a random gap.
    task automatic send_item(input logic [2:0] op, input elem_t v);
        int gap;
        start <= 1'b1;
        opcode <= op;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_set_command(op, v);
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic report_error(input string what, input set_result_t exp_r);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s: exp st %0d val %0d last %0d, got st %0d val %0d last %0d",
                     $realtime, what, exp_r.status, exp_r.elem, exp_r.last,
                     status, value_res, last);
    endtask

    // Compare each result item with the oldest prediction.
    always @(posedge clk)
    begin
        set_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (predicted_results.size() == 0)
            begin
                exp_r = '{status: 'x, elem: 'x, last: 'x};
                report_error("unexpected result", exp_r);
            end
            else
            begin
                exp_r = predicted_results.pop_front();
                if (status !== exp_r.status || value_res !== exp_r.elem ||
                    last !== exp_r.last)
                    report_error("result mismatch", exp_r);
            end
        end
    end

    // Operations on empty sets, a clear and the unused opcode.
    task automatic test_empty_and_unused;
        send_item(OPC_CLEAR, VAL_MAX);
        send_item(OPC_UNION, '0);
        send_item(OPC_UNUSED, VAL_MIN);
        send_item(OPC_A_MINUS_B, -1);
    endtask

    // Adds of extreme values, a duplicate, and every set operation.
    task automatic test_add_and_ops;
        send_item(OPC_ADD_A, VAL_MIN);
        send_item(OPC_ADD_A, VAL_MAX);
        send_item(OPC_ADD_A, '0);
        send_item(OPC_ADD_A, VAL_MIN);
        send_item(OPC_ADD_B, '0);
        send_item(OPC_ADD_B, -1);
        send_item(OPC_UNION, 32'sh1234_5678);
        send_item(OPC_INTER, VAL_MAX);
        send_item(OPC_A_MINUS_B, VAL_MIN);
        send_item(OPC_B_MINUS_A, '0);
    endtask

    // Fill A, refuse a new value, report a duplicate as present while full, overflow the union.
    task automatic test_capacity;
        no_gaps = 1'b1;
        for (int k = 1; k <= DEPTH - 3; k++)
            send_item(OPC_ADD_A, elem_t'(32'h0101_0101 * k));
        no_gaps = 1'b0;
        send_item(OPC_ADD_A, 32'sh5555_5555);
        send_item(OPC_ADD_A, '0);
        send_item(OPC_UNION, '0);
        send_item(OPC_B_MINUS_A, -1);
    endtask

    // Rounds: optional clear, random adds from a pool of 2 to 20 values, random operations.
    task automatic test_random_sequences;
        elem_t      pool [20];
        int         pool_n;
        int         n_adds;
        int         a_bias;
        int         items;
        logic [2:0] op;
        items = 0;
        while (items < 75)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                send_item(OPC_CLEAR, elem_t'($urandom));

            // Small pools give duplicates and overlap; large ones can fill a set.
            pool_n = $urandom_range(2, 20);
            for (int k = 0; k < pool_n; k++)
            begin
                case ($urandom_range(0, 11))
                    0:       pool[k] = VAL_MIN;
                    1:       pool[k] = VAL_MAX;
                    2:       pool[k] = '0;
                    3:       pool[k] = -1;
                    default: pool[k] = elem_t'($urandom);
                endcase
            end

            n_adds = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 24)
                                                 : $urandom_range(1, 10);
            a_bias = $urandom_range(0, 100);
            for (int k = 0; k < n_adds; k++)
            begin
                op = ($urandom_range(0, 99) < a_bias) ? OPC_ADD_A : OPC_ADD_B;
                send_item(op, pool[$urandom_range(0, pool_n - 1)]);
                items++;
            end

            for (int k = $urandom_range(1, 4); k > 0; k--)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(OPC_UNUSED, elem_t'($urandom));
                else
                begin
                    op = 3'($urandom_range(OPC_UNION, OPC_B_MINUS_A));
                    send_item(op, elem_t'($urandom));
                    items++;
                end
            end
        end
    endtask

    // Reset, run the tests in turn, drain the results and report.
    initial
    begin
        set_count[SET_A] = 0;
        set_count[SET_B] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_unused();
        test_add_and_ops();
        test_capacity();
        test_random_sequences();
        start <= 1'b0;

        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);

        if (error_count == 0 && predicted_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/sae_pkg.sv
rtl/sae_set_store.sv
rtl/sae_sequencer.sv
rtl/set_algebra_engine.sv
tb/set_algebra_engine_test.sv
